### sv/dtd_pkg.sv
package dtd_pkg;

    localparam int MAX_COLS_DEF = 7;

    localparam int TEXT_W = 8;
    localparam int COL_W  = 3;
    localparam int ROW_W  = 4;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    typedef struct packed {
        logic take;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic final_beat;
    } t_sts;

endpackage

### sv/dtd_if.sv
interface dtd_text_if;
    logic                         valid;
    logic                         ready;
    logic [dtd_pkg::TEXT_W-1:0]   text_byte;
    logic                         last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface dtd_plain_if;
    logic                         valid;
    logic                         ready;
    logic [dtd_pkg::TEXT_W-1:0]   plain_byte;
    logic                         final_res;

    modport source (output valid, output plain_byte, output final_res, input ready);
    modport sink   (input valid, input plain_byte, input final_res, output ready);
endinterface

interface dtd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [dtd_pkg::COL_W-1:0]    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/dtd_ram.sv
module dtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dtd_ctrl.sv
module dtd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_last,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  dtd_pkg::t_sts   i_sts,
    output dtd_pkg::t_cmd   o_cmd
);

    dtd_pkg::t_state r_state;
    dtd_pkg::t_state n_state;
    logic            in_acc;
    logic            out_acc;

    assign o_in_ready  = (r_state == dtd_pkg::S_IDLE);
    assign o_out_valid = (r_state == dtd_pkg::S_SHOW);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd.take = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            dtd_pkg::S_IDLE: begin
                o_cmd.take = in_acc;
                if (in_acc && i_in_last) begin
                    n_state = dtd_pkg::S_LOAD;
                end
            end
            dtd_pkg::S_LOAD: begin
                o_cmd.step = 1'b1;
                n_state    = dtd_pkg::S_SHOW;
            end
            dtd_pkg::S_SHOW: begin
                if (out_acc) begin
                    if (i_sts.final_beat) begin
                        n_state = dtd_pkg::S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = dtd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/dtd_dp.sv
module dtd_dp #(
    parameter int MAX_COLS = dtd_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtd_pkg::t_cmd               i_cmd,
    output dtd_pkg::t_sts               o_sts,
    input  logic [dtd_pkg::TEXT_W-1:0]  i_text_byte,
    input  logic                        i_last_byte,
    input  logic                        i_cfg_we,
    input  logic [dtd_pkg::COL_W-1:0]   i_cfg_data,
    output logic [dtd_pkg::TEXT_W-1:0]  o_plain_byte
);

    localparam int DEPTH = MAX_COLS * (MAX_COLS + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CW    = dtd_pkg::COL_W;
    localparam int RW    = dtd_pkg::ROW_W;

    logic [CW-1:0] r_cols;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_lim;
    logic [LW-1:0] r_cnt;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [LW-1:0] r_start;
    logic [LW-1:0] r_addr;
    logic          r_hit;

    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic [LW-1:0] n_start;
    logic [LW-1:0] n_addr;

    logic [CW-1:0]          eff_c;
    logic [LW-1:0]          c_l;
    logic [LW-1:0]          grid;
    logic                   room;
    logic [LW-1:0]          len_after;
    logic [RW-1:0]          diag;
    logic                   diag_end;
    logic [dtd_pkg::TEXT_W-1:0] rdata;

    always_comb begin
        if (r_cols == '0) begin
            eff_c = CW'(1);
        end else if (r_cols > CW'(MAX_COLS)) begin
            eff_c = CW'(MAX_COLS);
        end else begin
            eff_c = r_cols;
        end
    end

    assign c_l       = LW'(eff_c);
    assign grid      = LW'(c_l * (c_l + LW'(1)));
    assign room      = (r_len < grid);
    assign len_after = room ? r_len + LW'(1) : r_len;

    assign diag     = RW'(r_row) + RW'(r_col);
    assign diag_end = (r_col == '0) || (r_row == RW'(eff_c));

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_start = r_start;
        n_addr  = r_addr;
        if (diag_end) begin
            if (diag < RW'(eff_c) - RW'(1)) begin
                n_row   = '0;
                n_col   = CW'(diag + RW'(1));
                n_start = r_start + LW'(1);
            end else begin
                n_row   = diag + RW'(2) - RW'(eff_c);
                n_col   = eff_c - CW'(1);
                n_start = r_start + c_l;
            end
            n_addr = n_start;
        end else begin
            n_row  = r_row + RW'(1);
            n_col  = r_col - CW'(1);
            n_addr = r_addr + c_l - LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CW'(1);
            r_len  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cols <= i_cfg_data;
            end
            if (i_cmd.take) begin
                r_len <= i_last_byte ? '0 : len_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_last_byte) begin
            r_lim   <= len_after;
            r_cnt   <= (len_after < grid) ? len_after : grid;
            r_row   <= '0;
            r_col   <= '0;
            r_start <= '0;
            r_addr  <= '0;
        end else if (i_cmd.step) begin
            r_hit   <= (r_addr < r_lim);
            r_cnt   <= r_cnt - LW'(1);
            r_row   <= n_row;
            r_col   <= n_col;
            r_start <= n_start;
            r_addr  <= n_addr;
        end
    end

    dtd_ram #(
        .WIDTH (dtd_pkg::TEXT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && room),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_text_byte),
        .i_re    (i_cmd.step),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    assign o_sts.final_beat = (r_cnt == '0);
    assign o_plain_byte     = r_hit ? rdata : '0;

endmodule

### sv/diagonal_transposition_decode_top.sv
// Message bytes are taken one per cycle and stored row-major in a grid of
// columns+1 rows by columns columns; bytes past the grid size are dropped.
// The beat flagged last starts the readout, which walks the anti-diagonals
// and gives min(length, grid size) bytes, zero for cells beyond the message,
// with final_res on the last one. The readout first reads the first cell from
// RAM in the load state, then gives one byte per cycle while the sink is ready,
// set by the single read port of the cell memory. No input is taken during the
// readout. The column count should be written only while the block is idle.
module diagonal_transposition_decode_top #(
    parameter int MAX_COLS = dtd_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtd_text_if.sink    i_text,
    dtd_cfg_if.sink     i_cfg,
    dtd_plain_if.source o_plain
);

    dtd_pkg::t_cmd cmd;
    dtd_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    dtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .i_in_last   (i_text.last_byte),
        .o_in_ready  (i_text.ready),
        .o_out_valid (o_plain.valid),
        .i_out_ready (o_plain.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dtd_dp #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_text_byte  (i_text.text_byte),
        .i_last_byte  (i_text.last_byte),
        .i_cfg_we     (i_cfg.valid && i_cfg.ready),
        .i_cfg_data   (i_cfg.data),
        .o_plain_byte (o_plain.plain_byte)
    );

    assign o_plain.final_res = sts.final_beat;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_plain.valid && i_text.ready))
        else $error("input ready during readout");

    a_last_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_text.valid && i_text.ready && i_text.last_byte)
        |=> (!i_text.ready && !o_plain.valid) ##1 o_plain.valid)
        else $error("readout did not start after last beat");

    a_final_ends_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_plain.valid && o_plain.ready && o_plain.final_res)
        |=> (!o_plain.valid && i_text.ready))
        else $error("readout did not end after final beat");

endmodule
